@@ rtl/core/sbb_pkg.sv @@
// Shared types and constants for the separable box blur.
// Depends on nothing; used by every module under rtl/core.
`default_nettype none
package sbb_pkg;
   localparam int CH_NUM = 4;
   localparam int MAX_HEIGHT = 4096;
   localparam int CSR_RADIUS = 0;
   localparam int CSR_WIDTH  = 1;
   localparam int CSR_HEIGHT = 2;
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;
endpackage
`default_nettype wire

@@ rtl/core/separable_box_blur.sv @@
// Separable box blur, top level: stream ports, config and the item sequencer.
// Depends on sbb_pkg. Sums are built in the row and ring memories of this file.
//
// Usage: req_ carries one item per handshake: a pixel (op 0) in raster order
// or a drain tick (op 1). rsp_ returns the blurred pixel at (column, row)
// once every pixel its window needs has arrived; drain ticks release the
// outputs still pending after the last pixel of a frame, one per tick.
// csr_ writes window radius (0), frame width (1) and frame height (2); a
// write to any of these restarts the frame. Write only while the block is idle.
// Sequencing: a mid-row pixel completes at most one horizontal sum, a row-end
// pixel up to the last r+1; each is walked tap by tap over the row memory and
// written back to the ring memory. If an output's window is then complete,
// the vertical walk sums 2r+1 ring entries and a restoring divide forms the
// means. req_ takes no new item until the previous one has been handled.
// Reset: synchronous, clears positions and loads register defaults
// (r=3, 640x480); memory contents are undefined until written.
// Stall: a finished result waits in the output register; one more item is
// accepted and worked on, and its result holds until the register is free.
`default_nettype none
module separable_box_blur #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // sample_0, sample_1, sample_2, sample_3
   input  wire logic        req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // column, row, mean_0..mean_3, 2 zero bits
   output logic             rsp_tlast,   // frame_end
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);
   localparam int RING  = 2 * MAX_RADIUS + 2;
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(RING);
   localparam int RADW  = $clog2(MAX_RADIUS + 1);
   localparam int HW    = 8 + $clog2(2 * MAX_RADIUS + 1);
   localparam int TW    = HW + $clog2(2 * MAX_RADIUS + 1);
   // ceil(2^24 / RING): row / RING by reciprocal multiplication
   localparam int RECIP = (2**24 + RING - 1) / RING;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_HSTEP = 8'b00000010,
      S_HWB   = 8'b00000100,
      S_CHK   = 8'b00001000,
      S_VSTEP = 8'b00010000,
      S_DIV   = 8'b00100000,
      S_OUT   = 8'b01000000,
      S_DONE  = 8'b10000000
   } state_type;

   // configuration
   logic [4:0]  rad_ff;
   logic [10:0] wid_ff;
   logic [12:0] hgt_ff;
   logic [RADW-1:0] r;
   logic [10:0] w;
   logic [12:0] h;
   always_comb begin
      r = (rad_ff == 5'd0) ? RADW'(1) :
          ({27'd0, rad_ff} > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(rad_ff);
      w = (wid_ff == 11'd0) ? 11'd1 :
          ({21'd0, wid_ff} > MAX_WIDTH) ? 11'(MAX_WIDTH) : wid_ff;
      h = (hgt_ff == 13'd0) ? 13'd1 :
          (hgt_ff > 13'(sbb_pkg::MAX_HEIGHT)) ? 13'(sbb_pkg::MAX_HEIGHT) : hgt_ff;
   end

   state_type   st_ff;
   logic [12:0] ix_ff, iy_ff, ox_ff, oy_ff;
   logic        drain_ff;
   // horizontal job: columns hc_ff..hend_ff, tap index ti_ff
   logic [12:0] hc_ff, hend_ff;
   logic [12:0] cy_hold_ff;
   logic signed [14:0] ti_ff;
   logic [HW-1:0] hacc_ff [sbb_pkg::CH_NUM];
   logic [TW-1:0] vacc_ff [sbb_pkg::CH_NUM];
   logic        hpend_ff, vpend_ff;
   logic [5:0]  dcnt_ff;
   logic [TW:0] rem_ff [sbb_pkg::CH_NUM];
   logic [7:0]  q_ff [sbb_pkg::CH_NUM];
   logic [TW:0] dv_ff;

   // memories
   logic [31:0]  rowmem [MAX_WIDTH];
   logic [4*HW-1:0] ringmem [RING*MAX_WIDTH];
   logic [31:0]  rowq_ff;
   logic [4*HW-1:0] ringq_ff;
   logic         rwe, gwe;
   logic [XW-1:0] raddr, rwaddr;
   logic [RW+XW-1:0] gaddr, gwaddr;
   logic [4*HW-1:0] gwdata;
   always_ff @(posedge clock) begin
      if (rwe) rowmem[rwaddr] <= req_tdata;
      rowq_ff <= rowmem[raddr];
      if (gwe) ringmem[gwaddr] <= gwdata;
      ringq_ff <= ringmem[gaddr];
   end

   // helpers
   function automatic logic [RW-1:0] slot_of(input logic [12:0] y);
      logic [37:0] prod;
      logic [12:0] quo;
      prod = 38'(y) * 38'(RECIP);
      quo = prod[36:24];
      slot_of = RW'(y - 13'(quo * RING));
   endfunction
   function automatic logic [12:0] clampi(input logic signed [14:0] v,
                                           input logic [12:0] hi);
      if (v < 0) clampi = 13'd0;
      else if (v > $signed({2'b0, hi})) clampi = hi;
      else clampi = v[12:0];
   endfunction

   logic [12:0] ry, rx, tpos;
   logic ready_now, last_now;
   logic signed [14:0] rs;
   always_comb begin
      rs = 15'($unsigned(r));
      ry = ({1'b0, oy_ff} + 14'(r) < {1'b0, h}) ? oy_ff + 13'(r) : h - 13'd1;
      rx = ({1'b0, ox_ff} + 14'(r) < {3'b0, w}) ? ox_ff + 13'(r) : 13'(w) - 13'd1;
      ready_now = drain_ff || ry < iy_ff || (ry == iy_ff && rx < ix_ff);
      last_now = (ox_ff + 13'd1 >= 13'(w)) && (oy_ff + 13'd1 >= h);
      tpos = 13'd0;
      if (st_ff == S_HSTEP)
         tpos = clampi($signed({2'b0, hc_ff}) + ti_ff, 13'(w) - 13'd1);
      else if (st_ff == S_VSTEP)
         tpos = clampi($signed({2'b0, oy_ff}) + ti_ff, h - 13'd1);
   end

   assign req_tready = (st_ff == S_IDLE);
   assign csr_ready  = (st_ff == S_IDLE) && !rsp_tvalid;

   logic [12:0] cx, cy;
   always_comb begin
      cx = drain_ff ? 13'd0 : ix_ff;
      cy = drain_ff ? 13'd0 : iy_ff;
      rwe = req_tvalid && req_tready && req_tuser == sbb_pkg::OP_PIXEL;
      rwaddr = XW'(cx);
      raddr = XW'(tpos);
      gwe = (st_ff == S_HWB);
      gwaddr = {slot_of(cy_hold_ff), XW'(hc_ff)};
      gwdata = {hacc_ff[3], hacc_ff[2], hacc_ff[1], hacc_ff[0]};
      gaddr = {slot_of(tpos), XW'(ox_ff)};
   end

   logic [TW:0] nd;
   assign nd = (TW+1)'((2 * {6'd0, r} + 1) * (2 * {6'd0, r} + 1) * 2);

   logic [TW:0] num [sbb_pkg::CH_NUM];
   always_comb
      for (int c = 0; c < sbb_pkg::CH_NUM; c++)
         num[c] = {vacc_ff[c], 1'b0} + (nd >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rad_ff <= 5'd3; wid_ff <= 11'd640; hgt_ff <= 13'd480;
         ix_ff <= '0; iy_ff <= '0; ox_ff <= '0; oy_ff <= '0; drain_ff <= 1'b0;
         rsp_tvalid <= 1'b0; hpend_ff <= 1'b0; vpend_ff <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready && st_ff != S_OUT) rsp_tvalid <= 1'b0;
         unique case (st_ff)
            S_IDLE: begin
               // take config writes (restarting the frame) or accept an item
               if (csr_valid && csr_ready) begin
                  if (csr_index == 2'(sbb_pkg::CSR_RADIUS)) rad_ff <= csr_wdata[4:0];
                  if (csr_index == 2'(sbb_pkg::CSR_WIDTH))  wid_ff <= csr_wdata[10:0];
                  if (csr_index == 2'(sbb_pkg::CSR_HEIGHT)) hgt_ff <= csr_wdata;
                  if (csr_index <= 2'(sbb_pkg::CSR_HEIGHT)) begin
                     ix_ff <= '0; iy_ff <= '0; ox_ff <= '0; oy_ff <= '0;
                     drain_ff <= 1'b0;
                  end
               end else if (req_tvalid && req_tready) begin
                  if (req_tuser == sbb_pkg::OP_PIXEL) begin
                     cy_hold_ff <= cy;
                     if (drain_ff) begin
                        drain_ff <= 1'b0; ox_ff <= '0; oy_ff <= '0;
                     end
                     // set up the horizontal sums this pixel completes
                     if (cx + 13'd1 < 13'(w)) begin
                        hc_ff <= cx - 13'(r); hend_ff <= cx - 13'(r);
                        hpend_ff <= (cx >= 13'(r));
                     end else begin
                        hc_ff <= (13'(w) - 13'd1 >= 13'(r)) ? 13'(w) - 13'd1 - 13'(r) : 13'd0;
                        hend_ff <= 13'(w) - 13'd1;
                        hpend_ff <= 1'b1;
                     end
                     if (cx + 13'd1 < 13'(w)) begin
                        ix_ff <= cx + 13'd1; iy_ff <= cy;
                     end else begin
                        ix_ff <= '0;
                        if (cy + 13'd1 < h) iy_ff <= cy + 13'd1;
                        else begin iy_ff <= '0; drain_ff <= 1'b1; end
                     end
                     ti_ff <= -rs - 15'sd1;
                     for (int c = 0; c < sbb_pkg::CH_NUM; c++) hacc_ff[c] <= '0;
                     st_ff <= S_HSTEP;
                  end else st_ff <= S_CHK;
               end
            end
            S_HSTEP: begin
               // walk the row window one tap per cycle (first pass primes the read)
               if (!hpend_ff) st_ff <= S_CHK;
               else begin
                  if (ti_ff > -rs)
                     for (int c = 0; c < sbb_pkg::CH_NUM; c++)
                        hacc_ff[c] <= hacc_ff[c] + HW'(rowq_ff[8*c +: 8]);
                  if (ti_ff == rs + 15'sd1) st_ff <= S_HWB;
                  else ti_ff <= ti_ff + 15'sd1;
               end
            end
            S_HWB: begin
               // sum written this cycle; next column or done
               for (int c = 0; c < sbb_pkg::CH_NUM; c++) hacc_ff[c] <= '0;
               ti_ff <= -rs - 15'sd1;
               if (hc_ff == hend_ff) begin hpend_ff <= 1'b0; st_ff <= S_CHK; end
               else begin hc_ff <= hc_ff + 13'd1; st_ff <= S_HSTEP; end
            end
            S_CHK: begin
               if (ready_now) begin
                  ti_ff <= -rs - 15'sd1;
                  for (int c = 0; c < sbb_pkg::CH_NUM; c++) vacc_ff[c] <= '0;
                  st_ff <= S_VSTEP;
               end else st_ff <= S_IDLE;
            end
            S_VSTEP: begin
               // accumulate 2r+1 ring entries down the column
               if (ti_ff > -rs)
                  for (int c = 0; c < sbb_pkg::CH_NUM; c++)
                     vacc_ff[c] <= vacc_ff[c] + TW'(ringq_ff[HW*c +: HW]);
               if (ti_ff == rs + 15'sd1) begin
                  st_ff <= S_DIV; dcnt_ff <= 6'd8;
                  dv_ff <= nd;
               end else ti_ff <= ti_ff + 15'sd1;
            end
            S_DIV: begin
               // restoring divide, one quotient bit per cycle (quotient < 256)
               if (dcnt_ff == 6'd8)
                  for (int c = 0; c < sbb_pkg::CH_NUM; c++) begin
                     rem_ff[c] <= num[c]; q_ff[c] <= '0;
                  end
               else
                  for (int c = 0; c < sbb_pkg::CH_NUM; c++) begin
                     if (rem_ff[c] >= (dv_ff << dcnt_ff)) begin
                        rem_ff[c] <= rem_ff[c] - (dv_ff << dcnt_ff);
                        q_ff[c][dcnt_ff[2:0]] <= 1'b1;
                     end
                  end
               if (dcnt_ff == 6'd0) st_ff <= S_OUT;
               else if (dcnt_ff == 6'd8) dcnt_ff <= 6'd7;
               else dcnt_ff <= dcnt_ff - 6'd1;
            end
            S_OUT: begin
               // hold until the output register is free
               if (!rsp_tvalid || rsp_tready) begin
                  rsp_tvalid <= 1'b1;
                  rsp_tdata <= {2'b0, q_ff[3], q_ff[2], q_ff[1], q_ff[0],
                                oy_ff[11:0], ox_ff[9:0]};
                  rsp_tlast <= last_now;
                  if (last_now) begin ox_ff <= '0; oy_ff <= '0; drain_ff <= 1'b0; end
                  else if (ox_ff + 13'd1 < 13'(w)) ox_ff <= ox_ff + 13'd1;
                  else begin ox_ff <= '0; oy_ff <= oy_ff + 13'd1; end
                  st_ff <= S_DONE;
               end
            end
            S_DONE: st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
